// ===== rtl/core/mtrd_pkg.sv =====
package mtrd_pkg;

    // generator geometry
    localparam int STATE_WORDS  = 624;
    localparam int TWIST_OFFSET = 397;
    localparam int WORD_W       = 32;
    localparam int IDX_W        = $clog2(STATE_WORDS);
    localparam int DIV_CNT_W    = $clog2(WORD_W);

    // seeding and twist constants
    localparam logic [WORD_W-1:0] SEED_RESET   = 32'd4357;
    localparam logic [WORD_W-1:0] SEED_MULT    = 32'd69069;
    localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_b0df;
    localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
    localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;

    // which neighbor word the state memory is asked for
    typedef enum logic [1:0] {
        RD_CUR,
        RD_NEXT,
        RD_FAR
    } rd_sel_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic    load_mod;
        logic    fill_start;
        logic    fill_step;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    cap_cur;
        logic    cap_next;
        logic    twist_write;
        logic    div_start;
        logic    div_step;
        logic    out_load;
    } mtrd_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic mod_zero;
        logic fill_last;
        logic div_last;
    } mtrd_sts_t;

    // output tempering of one state word
    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

// ===== rtl/core/mersenne_twister_ranged_draw.sv =====
// channel   direction  handshake             payload
// in        input      in_valid / in_stall   modulus    (32 bits)
// out       output     out_valid / out_stall value      (32 bits)
// cfg       input      cfg_valid / cfg_ready seed_value (32 bits)
//
// a draw with a nonzero modulus runs in two parts from accept to result: one
// state word is twisted through the single read port of the state memory
// (three reads, one write), then a 32-step bit-serial remainder runs
// a zero modulus returns 0 and touches no state
// the first nonzero-modulus draw after reset or a seed write first fills all 624 state words
// reset loads seed 4357 and marks the state unseeded; the memory is not cleared
// a stalled result waits in the output register while the next draw runs; that
// draw then holds in its last state, with in_stall high, until the beat is taken
module mersenne_twister_ranged_draw (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [mtrd_pkg::WORD_W-1:0] modulus,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [mtrd_pkg::WORD_W-1:0] value,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [mtrd_pkg::WORD_W-1:0] seed_value
);

    import mtrd_pkg::*;

    mtrd_cmd_t         cmd;
    mtrd_sts_t         sts;
    logic              cfg_write;
    logic              ram_wr_en;
    logic [IDX_W-1:0]  ram_wr_addr;
    logic [WORD_W-1:0] ram_wr_data;
    logic              ram_rd_en;
    logic [IDX_W-1:0]  ram_rd_addr;
    logic [WORD_W-1:0] ram_rd_data;

    // seed register write beat
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // controller
    mtrd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_write (cfg_write),
        .cmd       (cmd),
        .sts       (sts)
    );

    // datapath
    mtrd_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_write   (cfg_write),
        .cfg_seed    (seed_value),
        .modulus     (modulus),
        .value       (value),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    // generator state words
    mtrd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STATE_WORDS)
    ) u_state_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // an accepted beat keeps the input side busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted twice in a row");

    // a new result beat only follows work on an accepted beat
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
    else $error("result beat without a draw in work");

    // state memory addresses stay inside the word array
    assert property (@(posedge clk) disable iff (!rst_n)
        (ram_wr_en || ram_rd_en) |->
        (ram_wr_addr < IDX_W'(STATE_WORDS) && ram_rd_addr < IDX_W'(STATE_WORDS)))
    else $error("state memory address out of range");

    // the memory is never written while a draw is not in work
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> in_stall)
    else $error("state memory written while idle");

endmodule

// ===== rtl/core/mtrd_ram.sv =====
module mtrd_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 624,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/mtrd_ctrl.sv =====
module mtrd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  logic               cfg_write,
    output mtrd_pkg::mtrd_cmd_t cmd,
    input  mtrd_pkg::mtrd_sts_t sts
);

    import mtrd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_FILL,
        S_RD_CUR,
        S_RD_NEXT,
        S_RD_FAR,
        S_TWIST,
        S_TEMPER,
        S_DIV,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   seeded_reg, seeded_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        seeded_next = seeded_reg;
        cmd         = '0;
        cmd.rd_sel  = RD_CUR;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_mod = 1'b1;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.mod_zero)
                begin
                    state_next = S_DONE;
                end
                else if (!seeded_reg)
                begin
                    cmd.fill_start = 1'b1;
                    state_next     = S_FILL;
                end
                else
                begin
                    state_next = S_RD_CUR;
                end
            end
            S_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (sts.fill_last)
                begin
                    seeded_next = 1'b1;
                    state_next  = S_RD_CUR;
                end
            end
            S_RD_CUR:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_CUR;
                state_next = S_RD_NEXT;
            end
            S_RD_NEXT:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = RD_NEXT;
                cmd.cap_cur = 1'b1;
                state_next  = S_RD_FAR;
            end
            S_RD_FAR:
            begin
                cmd.rd_en    = 1'b1;
                cmd.rd_sel   = RD_FAR;
                cmd.cap_next = 1'b1;
                state_next   = S_TWIST;
            end
            S_TWIST:
            begin
                cmd.twist_write = 1'b1;
                state_next      = S_TEMPER;
            end
            S_TEMPER:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // a seed write forces a refill before the next draw
        if (cfg_write)
        begin
            seeded_next = 1'b0;
        end
    end

    // output beat holding register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seeded_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seeded_reg    <= seeded_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/core/mtrd_datapath.sv =====
module mtrd_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  mtrd_pkg::mtrd_cmd_t                  cmd,
    output mtrd_pkg::mtrd_sts_t                  sts,
    input  logic                                 cfg_write,
    input  logic [mtrd_pkg::WORD_W-1:0]          cfg_seed,
    input  logic [mtrd_pkg::WORD_W-1:0]          modulus,
    output logic [mtrd_pkg::WORD_W-1:0]          value,
    output logic                                 ram_wr_en,
    output logic [mtrd_pkg::IDX_W-1:0]           ram_wr_addr,
    output logic [mtrd_pkg::WORD_W-1:0]          ram_wr_data,
    output logic                                 ram_rd_en,
    output logic [mtrd_pkg::IDX_W-1:0]           ram_rd_addr,
    input  logic [mtrd_pkg::WORD_W-1:0]          ram_rd_data
);

    import mtrd_pkg::*;

    localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(STATE_WORDS - 1);
    localparam logic [IDX_W-1:0] FAR_LIMIT  = IDX_W'(STATE_WORDS - TWIST_OFFSET);
    localparam logic [IDX_W-1:0] FAR_ADD    = IDX_W'(TWIST_OFFSET);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(WORD_W - 1);

    logic [WORD_W-1:0]    seed_reg, seed_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [WORD_W-1:0]    mod_reg, mod_next;
    logic [WORD_W-1:0]    word_reg, word_next;
    logic [WORD_W-1:0]    cur_reg, cur_next;
    logic [WORD_W-1:0]    nxt_reg, nxt_next;
    logic [WORD_W-1:0]    y_reg, y_next;
    logic [WORD_W-1:0]    dividend_reg, dividend_next;
    logic [WORD_W-1:0]    rem_reg, rem_next;
    logic [WORD_W-1:0]    value_reg, value_next;

    logic [IDX_W-1:0]  idx_inc;
    logic [IDX_W-1:0]  idx_far;
    logic [WORD_W-1:0] mix_y;
    logic [WORD_W-1:0] twist_word;
    logic [WORD_W:0]   trial;
    logic [WORD_W:0]   trial_diff;

    // neighbor indexes around the current word
    assign idx_inc = (idx_reg == IDX_LAST) ? '0 : idx_reg + 1'b1;
    assign idx_far = (idx_reg < FAR_LIMIT) ? idx_reg + FAR_ADD : idx_reg - FAR_LIMIT;

    // one-word twist from current, next and far words
    assign mix_y      = {cur_reg[WORD_W-1], nxt_reg[WORD_W-2:0]};
    assign twist_word = ram_rd_data ^ (mix_y >> 1) ^ (mix_y[0] ? TWIST_MATRIX : '0);

    // restoring remainder step
    assign trial      = {rem_reg, dividend_reg[WORD_W-1]};
    assign trial_diff = trial - {1'b0, mod_reg};

    // state memory requests
    always_comb
    begin
        ram_wr_en   = cmd.fill_step || cmd.twist_write;
        ram_wr_addr = idx_reg;
        ram_wr_data = cmd.fill_step ? word_reg : twist_word;
        ram_rd_en   = cmd.rd_en;
        case (cmd.rd_sel)
            RD_NEXT: ram_rd_addr = idx_inc;
            RD_FAR:  ram_rd_addr = idx_far;
            default: ram_rd_addr = idx_reg;
        endcase
    end

    // control registers: seed, word index, divide count
    always_comb
    begin
        seed_next    = seed_reg;
        idx_next     = idx_reg;
        div_cnt_next = div_cnt_reg;
        if (cfg_write)
        begin
            seed_next = cfg_seed;
        end
        if (cmd.fill_start)
        begin
            idx_next = '0;
        end
        else if (cmd.fill_step || cmd.twist_write)
        begin
            idx_next = idx_inc;
        end
        if (cmd.div_start)
        begin
            div_cnt_next = '0;
        end
        else if (cmd.div_step)
        begin
            div_cnt_next = div_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg    <= SEED_RESET;
            idx_reg     <= '0;
            div_cnt_reg <= '0;
        end
        else
        begin
            seed_reg    <= seed_next;
            idx_reg     <= idx_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    // payload registers
    always_comb
    begin
        mod_next      = mod_reg;
        word_next     = word_reg;
        cur_next      = cur_reg;
        nxt_next      = nxt_reg;
        y_next        = y_reg;
        dividend_next = dividend_reg;
        rem_next      = rem_reg;
        value_next    = value_reg;
        if (cmd.load_mod)
        begin
            mod_next = modulus;
            rem_next = '0;
        end
        if (cmd.fill_start)
        begin
            word_next = seed_reg;
        end
        else if (cmd.fill_step)
        begin
            word_next = word_reg * SEED_MULT;
        end
        if (cmd.cap_cur)
        begin
            cur_next = ram_rd_data;
        end
        if (cmd.cap_next)
        begin
            nxt_next = ram_rd_data;
        end
        if (cmd.twist_write)
        begin
            y_next = twist_word;
        end
        if (cmd.div_start)
        begin
            dividend_next = temper(y_reg);
            rem_next      = '0;
        end
        else if (cmd.div_step)
        begin
            dividend_next = {dividend_reg[WORD_W-2:0], 1'b0};
            rem_next      = trial_diff[WORD_W] ? trial[WORD_W-1:0] : trial_diff[WORD_W-1:0];
        end
        if (cmd.out_load)
        begin
            value_next = rem_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mod_reg      <= mod_next;
        word_reg     <= word_next;
        cur_reg      <= cur_next;
        nxt_reg      <= nxt_next;
        y_reg        <= y_next;
        dividend_reg <= dividend_next;
        rem_reg      <= rem_next;
        value_reg    <= value_next;
    end

    // status
    assign sts.mod_zero  = (mod_reg == '0);
    assign sts.fill_last = (idx_reg == IDX_LAST);
    assign sts.div_last  = (div_cnt_reg == DIV_LAST);

    assign value = value_reg;

endmodule
